>>> rtl/vfcm_pkg.sv
`default_nettype none

package vfcm_pkg;

  localparam int unsigned CoordW    = 5;
  localparam int unsigned HeightW   = 6;
  localparam int unsigned DirW      = 3;
  localparam int unsigned VertW     = 22;
  localparam int unsigned NumDirs   = 6;
  localparam int unsigned FaceVerts = 4;
  localparam int unsigned NumReads  = 5;
  localparam int unsigned SelW      = 3;

  typedef enum logic [1:0] {
    OpSetColumn  = 2'd0,
    OpMesh       = 2'd1,
    OpClearCount = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StRead,
    StLast,
    StBuild,
    StEmit
  } state_e;

  localparam logic [SelW-1:0] SelCenter = 3'd0;
  localparam logic [SelW-1:0] SelXPos   = 3'd1;
  localparam logic [SelW-1:0] SelYPos   = 3'd2;
  localparam logic [SelW-1:0] SelXNeg   = 3'd3;
  localparam logic [SelW-1:0] SelYNeg   = 3'd4;

  localparam logic [DirW-1:0] DirXPos = 3'd0;
  localparam logic [DirW-1:0] DirYPos = 3'd1;
  localparam logic [DirW-1:0] DirXNeg = 3'd2;
  localparam logic [DirW-1:0] DirYNeg = 3'd3;
  localparam logic [DirW-1:0] DirZPos = 3'd4;
  localparam logic [DirW-1:0] DirZNeg = 3'd5;

  typedef struct packed {
    logic            clear_wr;
    logic            accept;
    logic            read_en;
    logic [SelW-1:0] read_sel;
    logic            build;
    logic            emit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic mesh_go;
    logic mask_empty;
    logic mask_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/vfcm_ram.sv
`default_nettype none

module vfcm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/vfcm_ctrl.sv
`default_nettype none

module vfcm_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  input  wire vfcm_pkg::sts_t sts_i,
  output      vfcm_pkg::cmd_t cmd_o
);

  import vfcm_pkg::*;

  state_e          state_q, state_d;
  logic [SelW-1:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      StClear: begin
        if (sts_i.clear_done) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        step_d = SelCenter;
        if (in_valid_i && sts_i.mesh_go) begin
          state_d = StRead;
        end
      end
      StRead: begin
        step_d = step_q + 3'd1;
        if (step_q == 3'(NumReads - 1)) begin
          state_d = StLast;
        end
      end
      StLast: begin
        state_d = StBuild;
      end
      StBuild: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (sts_i.mask_empty) begin
          state_d = StIdle;
        end else if (sts_i.out_free && sts_i.mask_last) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StClear: begin
        cmd_o.clear_wr = 1'b1;
      end
      StIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      StRead: begin
        cmd_o.read_en  = 1'b1;
        cmd_o.read_sel = step_q;
      end
      StBuild: begin
        cmd_o.build = 1'b1;
      end
      StEmit: begin
        cmd_o.emit = !sts_i.mask_empty && sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      step_q  <= SelCenter;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRead |-> step_q < 3'(NumReads))
    else $error("read step out of range");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("face emitted into a busy output register");

  a_last_face_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && sts_i.mask_last |=> state_q == StIdle)
    else $error("controller did not return to idle after the last face");

endmodule

`default_nettype wire

>>> rtl/vfcm_datapath.sv
`default_nettype none

module vfcm_datapath #(
  parameter int unsigned CHUNK_SIZE = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire vfcm_pkg::cmd_t                  cmd_i,
  output      vfcm_pkg::sts_t                  sts_o,
  input  wire logic [1:0]                      operation_i,
  input  wire logic [vfcm_pkg::CoordW-1:0]     pos_x_i,
  input  wire logic [vfcm_pkg::CoordW-1:0]     pos_y_i,
  input  wire logic [vfcm_pkg::CoordW-1:0]     pos_z_i,
  input  wire logic [vfcm_pkg::HeightW-1:0]    column_height_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      logic [vfcm_pkg::CoordW-1:0]     face_x_o,
  output      logic [vfcm_pkg::CoordW-1:0]     face_y_o,
  output      logic [vfcm_pkg::CoordW-1:0]     face_z_o,
  output      logic [vfcm_pkg::DirW-1:0]       face_dir_o,
  output      logic [vfcm_pkg::VertW-1:0]      first_vertex_o,
  output      logic                            is_last_o
);

  import vfcm_pkg::*;

  // Coordinates are five bits wide, so only the first 32 columns of each axis can ever be solid.
  // A column keeps one bit more in a larger chunk, so that the top voxel sees the one above it.
  localparam int unsigned Lim   = (CHUNK_SIZE > 32) ? 32 : CHUNK_SIZE;
  localparam int unsigned ZLim  = (CHUNK_SIZE > 32) ? 33 : CHUNK_SIZE;
  localparam int unsigned AW    = $clog2(Lim);
  localparam int unsigned ZW    = $clog2(ZLim);
  localparam int unsigned Depth = 2 ** (2 * AW);
  localparam logic [HeightW-1:0] LimC  = HeightW'(Lim);
  localparam logic [HeightW-1:0] ZLimC = HeightW'(ZLim);

  logic [CoordW-1:0] x_q, y_q, z_q;
  logic              x_in, y_in, z_in;
  logic              wr_en;
  logic [2*AW-1:0]   waddr, raddr;
  logic [ZLim-1:0]   wdata, height_bits, rdata;
  logic [2*AW-1:0]   clr_q;
  logic              xp_edge, yp_edge, zp_edge, xn_edge, yn_edge, zn_edge;
  logic [AW-1:0]     xa, ya;
  logic [ZW-1:0]     za;
  logic              rd_pend_q;
  logic [SelW-1:0]   rd_sel_q;
  logic              solid_q, up_q, dn_q;
  logic [3:0]        nb_q;
  logic [NumDirs-1:0] vis, rem_q, rem_d, pick_hot;
  logic [DirW-1:0]   pick;
  logic [VertW-1:0]  vcnt_q;
  logic              out_valid_q;

  assign x_in = {1'b0, pos_x_i} < LimC;
  assign y_in = {1'b0, pos_y_i} < LimC;
  assign z_in = {1'b0, pos_z_i} < ZLimC;

  always_comb begin
    for (int i = 0; i < ZLim; i++) begin
      height_bits[i] = column_height_i > HeightW'(i);
    end
  end

  assign wr_en = cmd_i.clear_wr ||
                 (cmd_i.accept && operation_i == OpSetColumn && x_in && y_in);
  assign waddr = cmd_i.clear_wr ? clr_q : {pos_y_i[AW-1:0], pos_x_i[AW-1:0]};
  assign wdata = cmd_i.clear_wr ? '0 : height_bits;

  assign xa = x_q[AW-1:0];
  assign ya = y_q[AW-1:0];
  assign za = ZW'(z_q);

  assign xp_edge = ({1'b0, x_q} + 6'd1) >= LimC;
  assign yp_edge = ({1'b0, y_q} + 6'd1) >= LimC;
  assign zp_edge = ({1'b0, z_q} + 6'd1) >= ZLimC;
  assign xn_edge = x_q == '0;
  assign yn_edge = y_q == '0;
  assign zn_edge = z_q == '0;

  // An edge neighbor is never read; its slot just rereads the center column.
  always_comb begin
    raddr = {ya, xa};
    case (cmd_i.read_sel)
      SelCenter: raddr = {ya, xa};
      SelXPos:   raddr = xp_edge ? {ya, xa} : {ya, xa + AW'(1)};
      SelYPos:   raddr = yp_edge ? {ya, xa} : {ya + AW'(1), xa};
      SelXNeg:   raddr = xn_edge ? {ya, xa} : {ya, xa - AW'(1)};
      SelYNeg:   raddr = yn_edge ? {ya, xa} : {ya - AW'(1), xa};
      default:   raddr = {ya, xa};
    endcase
  end

  vfcm_ram #(
    .Width (ZLim),
    .Depth (Depth)
  ) u_column_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.read_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q <= pos_x_i;
      y_q <= pos_y_i;
      z_q <= pos_z_i;
    end
    if (rd_pend_q) begin
      case (rd_sel_q)
        SelCenter: begin
          solid_q <= rdata[za];
          up_q    <= zp_edge ? 1'b0 : rdata[za + ZW'(1)];
          dn_q    <= zn_edge ? 1'b0 : rdata[za - ZW'(1)];
        end
        SelXPos: nb_q[0] <= rdata[za];
        SelYPos: nb_q[1] <= rdata[za];
        SelXNeg: nb_q[2] <= rdata[za];
        SelYNeg: nb_q[3] <= rdata[za];
        default: nb_q    <= nb_q;
      endcase
    end
  end

  assign vis[DirXPos] = xp_edge || !nb_q[0];
  assign vis[DirYPos] = yp_edge || !nb_q[1];
  assign vis[DirXNeg] = xn_edge || !nb_q[2];
  assign vis[DirYNeg] = yn_edge || !nb_q[3];
  assign vis[DirZPos] = !up_q;
  assign vis[DirZNeg] = !dn_q;

  always_comb begin
    pick = DirXPos;
    for (int i = NumDirs - 1; i >= 0; i--) begin
      if (rem_q[i]) begin
        pick = DirW'(i);
      end
    end
  end

  assign pick_hot = NumDirs'(1) << pick;

  always_comb begin
    rem_d = rem_q;
    if (cmd_i.build) begin
      rem_d = solid_q ? vis : '0;
    end else if (cmd_i.emit) begin
      rem_d = rem_q & ~pick_hot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      rd_pend_q   <= 1'b0;
      rd_sel_q    <= SelCenter;
      rem_q       <= '0;
      vcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_wr) begin
        clr_q <= clr_q + (2*AW)'(1);
      end
      rd_pend_q <= cmd_i.read_en;
      rd_sel_q  <= cmd_i.read_sel;
      rem_q     <= rem_d;
      if (cmd_i.accept && operation_i == OpClearCount) begin
        vcnt_q <= '0;
      end else if (cmd_i.emit) begin
        vcnt_q <= vcnt_q + VertW'(FaceVerts);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      face_x_o       <= x_q;
      face_y_o       <= y_q;
      face_z_o       <= z_q;
      face_dir_o     <= pick;
      first_vertex_o <= vcnt_q;
      is_last_o      <= (rem_q & ~pick_hot) == '0;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.clear_done = &clr_q;
  assign sts_o.mesh_go    = operation_i == OpMesh && x_in && y_in && z_in;
  assign sts_o.mask_empty = rem_q == '0;
  assign sts_o.mask_last  = (rem_q & (rem_q - NumDirs'(1))) == '0;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  a_emit_has_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> rem_q != '0)
    else $error("face emitted with no visible face left");

  a_no_write_during_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && cmd_i.read_en))
    else $error("column write collides with a neighbor read");

  a_vertex_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> vcnt_q == $past(vcnt_q) + VertW'(FaceVerts))
    else $error("vertex base did not advance by one face");

  a_read_data_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> $past(cmd_i.read_en))
    else $error("read capture without a read");

endmodule

`default_nettype wire

>>> rtl/voxel_face_culling_mesher_top.sv
// Channel  Direction  Transfer condition         Payload
// in       input      in_valid_i & in_ready_o    operation, pos_x, pos_y, pos_z, column_height
// out      output     out_valid_o & out_ready_i  face_x, face_y, face_z, face_dir,
//                                                first_vertex, is_last
//
// Non-mesh transfers and mesh transfers outside the chunk leave the controller idle and ready.
// Other mesh transfers read the center column and four neighbor columns one after another on
// one RAM port, then build the face mask and emit each visible face.
// After reset the column RAM is cleared one column per cycle, all 4**clog2(min(CHUNK_SIZE,
// 32)) columns (1024 by default), and no input is taken until the pass ends.
// A stalled output holds face emission; input is taken again once the last face is registered.
`default_nettype none

module voxel_face_culling_mesher_top #(
  parameter int unsigned CHUNK_SIZE = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic [1:0]                   operation_i,
  input  wire logic [vfcm_pkg::CoordW-1:0]  pos_x_i,
  input  wire logic [vfcm_pkg::CoordW-1:0]  pos_y_i,
  input  wire logic [vfcm_pkg::CoordW-1:0]  pos_z_i,
  input  wire logic [vfcm_pkg::HeightW-1:0] column_height_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic [vfcm_pkg::CoordW-1:0]  face_x_o,
  output      logic [vfcm_pkg::CoordW-1:0]  face_y_o,
  output      logic [vfcm_pkg::CoordW-1:0]  face_z_o,
  output      logic [vfcm_pkg::DirW-1:0]    face_dir_o,
  output      logic [vfcm_pkg::VertW-1:0]   first_vertex_o,
  output      logic                         is_last_o
);

  import vfcm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  vfcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vfcm_datapath #(
    .CHUNK_SIZE (CHUNK_SIZE)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operation_i     (operation_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .column_height_i (column_height_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .face_x_o        (face_x_o),
    .face_y_o        (face_y_o),
    .face_z_o        (face_z_o),
    .face_dir_o      (face_dir_o),
    .first_vertex_o  (first_vertex_o),
    .is_last_o       (is_last_o)
  );

endmodule

`default_nettype wire

>>> tb/sv/voxel_face_culling_mesher_top_test.sv
`timescale 1ns / 1ps

module voxel_face_culling_mesher_top_test;
  import vfcm_pkg::*;

  localparam int unsigned ChunkSize = 32;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned ReportLimit = 10;
  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic [DirW-1:0]   dir;
    logic [VertW-1:0]  vert;
    logic              last;
  } face_t;

  // Tracks the voxel grid and the vertex base, and holds the faces still owed by the block.
  class face_scoreboard;
    logic [ChunkSize-1:0] columns [ChunkSize][ChunkSize];
    logic [VertW-1:0]     vert_base;
    face_t                faces_due[$];
    int unsigned          failures;

    function new();
      foreach (columns[i, j]) columns[i][j] = '0;
      vert_base = '0;
      failures = 0;
    endfunction

    function bit solid(int x, int y, int z);
      if (x < 0 || y < 0 || z < 0 || x >= ChunkSize || y >= ChunkSize || z >= ChunkSize) begin
        return 1'b0;
      end
      return columns[y][x][z];
    endfunction

    function int unsigned column_top(int x, int y);
      return $countones(columns[y][x]);
    endfunction

    function int unsigned pending();
      return faces_due.size();
    endfunction

    function void note_transfer(logic [1:0] op, logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                                logic [CoordW-1:0] z, logic [HeightW-1:0] h);
      logic [ChunkSize:0] fill;
      int unsigned        hh;
      int                 nx;
      int                 ny;
      int                 nz;
      int                 n;
      face_t              found[NumDirs];
      n = 0;
      case (op)
        OpSetColumn: begin
          hh = (h > ChunkSize) ? ChunkSize : h;
          fill = ({{ChunkSize{1'b0}}, 1'b1} << hh) - 1'b1;
          columns[y][x] = fill[ChunkSize-1:0];
        end
        OpClearCount: begin
          vert_base = '0;
        end
        OpMesh: begin
          if (solid(x, y, z)) begin
            for (int d = 0; d < NumDirs; d++) begin
              nx = x;
              ny = y;
              nz = z;
              case (DirW'(d))
                DirXPos: nx = nx + 1;
                DirYPos: ny = ny + 1;
                DirXNeg: nx = nx - 1;
                DirYNeg: ny = ny - 1;
                DirZPos: nz = nz + 1;
                default: nz = nz - 1;
              endcase
              if (!solid(nx, ny, nz)) begin
                found[n] = '{x: x, y: y, z: z, dir: DirW'(d), vert: vert_base, last: 1'b0};
                vert_base = vert_base + VertW'(FaceVerts);
                n++;
              end
            end
            if (n > 0) found[n-1].last = 1'b1;
            for (int i = 0; i < n; i++) faces_due.push_back(found[i]);
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_face(face_t got);
      face_t want;
      if (faces_due.size() == 0) begin
        failures++;
        if (failures <= ReportLimit) begin
          $display("unexpected face x=%0d y=%0d z=%0d dir=%0d vert=%0d last=%0b",
                   got.x, got.y, got.z, got.dir, got.vert, got.last);
        end
        return;
      end
      want = faces_due.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= ReportLimit) begin
          $display("face mismatch: expected x=%0d y=%0d z=%0d dir=%0d vert=%0d last=%0b",
                   want.x, want.y, want.z, want.dir, want.vert, want.last);
          $display("               actual   x=%0d y=%0d z=%0d dir=%0d vert=%0d last=%0b",
                   got.x, got.y, got.z, got.dir, got.vert, got.last);
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          operation_i;
  logic [CoordW-1:0]   pos_x_i;
  logic [CoordW-1:0]   pos_y_i;
  logic [CoordW-1:0]   pos_z_i;
  logic [HeightW-1:0]  column_height_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [CoordW-1:0]   face_x_o;
  logic [CoordW-1:0]   face_y_o;
  logic [CoordW-1:0]   face_z_o;
  logic [DirW-1:0]     face_dir_o;
  logic [VertW-1:0]    first_vertex_o;
  logic                is_last_o;

  face_scoreboard sb;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  int unsigned    rx_hold;
  int unsigned    quiet_cycles;

  voxel_face_culling_mesher_top #(
    .CHUNK_SIZE(ChunkSize)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .column_height_i(column_height_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .face_x_o       (face_x_o),
    .face_y_o       (face_y_o),
    .face_z_o       (face_z_o),
    .face_dir_o     (face_dir_o),
    .first_vertex_o (first_vertex_o),
    .is_last_o      (is_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_transfer(operation_i, pos_x_i, pos_y_i, pos_z_i, column_height_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_face('{x: face_x_o, y: face_y_o, z: face_z_o, dir: face_dir_o,
                      vert: first_vertex_o, last: is_last_o});
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_ready_i = 1'b0;
        rx_hold--;
      end else begin
        out_ready_i = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("voxel_face_culling_mesher_top verification failed");
    $finish;
  end

  task automatic send_item(logic [1:0] op, logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                           logic [CoordW-1:0] z, logic [HeightW-1:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    operation_i = op;
    pos_x_i = x;
    pos_y_i = y;
    pos_z_i = z;
    column_height_i = h;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic logic [CoordW-1:0] pick_coord(int unsigned region);
    case (region)
      0: return CoordW'($urandom_range(3));
      1: return CoordW'($urandom_range(31, 28));
      default: return CoordW'($urandom_range(31));
    endcase
  endfunction

  // Columns cluster in the chunk corners so that neighbors are often solid, and most
  // mesh transfers land on a solid voxel.
  task automatic send_random(output bit counted);
    logic [1:0]         op;
    logic [CoordW-1:0]  x;
    logic [CoordW-1:0]  y;
    logic [CoordW-1:0]  z;
    logic [HeightW-1:0] h;
    int unsigned        region;
    int unsigned        sel;
    int unsigned        top;
    region = $urandom_range(2);
    sel = $urandom_range(99);
    x = pick_coord(region);
    y = pick_coord(region);
    z = CoordW'($urandom);
    if (sel < 30) op = OpSetColumn;
    else if (sel < 90) op = OpMesh;
    else if (sel < 95) op = OpClearCount;
    else op = OpUnused;
    if ($urandom_range(3) == 0) h = HeightW'($urandom_range(63));
    else h = HeightW'($urandom_range(ChunkSize));
    if (op == OpMesh) begin
      top = sb.column_top(x, y);
      if (top > 0 && $urandom_range(3) != 0) z = CoordW'($urandom_range(top - 1));
    end
    send_item(op, x, y, z, h);
    counted = (op != OpUnused);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned sent;
    bit          counted;
    sent = 0;
    while (sent < count) begin
      send_random(counted);
      if (counted) sent++;
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = OpSetColumn;
    pos_x_i = '0;
    pos_y_i = '0;
    pos_z_i = '0;
    column_height_i = '0;
    rx_hold = 0;
    send_idle_pct = 23;
    recv_idle_pct = 87;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(OpMesh, 5'd0, 5'd0, 5'd0, 6'd0);
    send_item(OpSetColumn, 5'd0, 5'd0, 5'd0, 6'd63);
    send_item(OpMesh, 5'd0, 5'd0, 5'd0, 6'd0);
    send_item(OpMesh, 5'd0, 5'd0, 5'd31, 6'd0);
    send_item(OpSetColumn, 5'd31, 5'd31, 5'd0, 6'd32);
    send_item(OpMesh, 5'd31, 5'd31, 5'd31, 6'd0);
    send_item(OpSetColumn, 5'd1, 5'd0, 5'd0, 6'd33);
    send_item(OpMesh, 5'd0, 5'd0, 5'd5, 6'd0);
    send_item(OpSetColumn, 5'd15, 5'd15, 5'd0, 6'd1);
    send_item(OpMesh, 5'd15, 5'd15, 5'd0, 6'd0);
    send_item(OpMesh, 5'd15, 5'd15, 5'd1, 6'd0);
    send_item(OpClearCount, 5'd0, 5'd0, 5'd0, 6'd0);
    send_item(OpMesh, 5'd31, 5'd31, 5'd0, 6'd0);
    send_item(OpUnused, 5'd31, 5'd31, 5'd31, 6'd63);
    send_item(OpSetColumn, 5'd15, 5'd15, 5'd0, 6'd0);
    send_item(OpMesh, 5'd15, 5'd15, 5'd0, 6'd0);
    send_item(OpSetColumn, 5'd4, 5'd5, 5'd0, 6'd32);
    send_item(OpSetColumn, 5'd6, 5'd5, 5'd0, 6'd32);
    send_item(OpSetColumn, 5'd5, 5'd4, 5'd0, 6'd32);
    send_item(OpSetColumn, 5'd5, 5'd6, 5'd0, 6'd32);
    send_item(OpSetColumn, 5'd5, 5'd5, 5'd0, 6'd20);
    send_item(OpMesh, 5'd5, 5'd5, 5'd10, 6'd0);
    send_item(OpMesh, 5'd5, 5'd5, 5'd19, 6'd0);
    send_item(OpMesh, 5'd0, 5'd0, 5'd30, 6'd0);

    run_random(135);
    wait_drained();

    send_idle_pct = 87;
    recv_idle_pct = 23;
    run_random(135);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    rx_hold = 400;
    run_random(135);

    wait_drained();
    repeat (40) @(negedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("voxel_face_culling_mesher_top verification clean");
    end else begin
      $display("voxel_face_culling_mesher_top verification failed");
    end
    $finish;
  end

endmodule
